### hw/rtl/k_way_sorted_merge_top_assert.svh
// Assertion macros shared by the k-way merge checker.
`ifndef K_WAY_SORTED_MERGE_TOP_ASSERT_SVH
`define K_WAY_SORTED_MERGE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define KWSM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define KWSM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define KWSM_ASSERT_ALW(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/kwsm_pkg.sv
// Types, constants and the compare function of the k-way merge.
package kwsm_pkg;

    localparam int LANES      = 8;
    localparam int VALUE_BITS = 32;
    localparam int LANE_BITS  = 3;
    localparam int CFG_BITS   = 4;
    localparam int FILL_BITS  = $clog2(LANES + 1);
    localparam int LEVELS     = $clog2(LANES);
    localparam int SLOTS      = 1 << LEVELS;
    localparam int LEVEL_BITS = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    typedef struct packed {
        logic [LANE_BITS-1:0]         item_lane;
        logic signed [VALUE_BITS-1:0] item_value;
        logic                         lane_end;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] out_value;
        logic [LANE_BITS-1:0]         out_lane;
        logic                         has_value;
        logic                         merge_done;
        logic                         seq_error;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_EMIT
    } t_state;

    typedef enum logic {
        K_VALUE,
        K_ERROR
    } t_kind;

    // One contender of the minimum search
    typedef struct packed {
        logic                         live;
        logic signed [VALUE_BITS-1:0] value;
        logic [LANE_BITS-1:0]         lane;
    } t_cand;

    // Controller to datapath
    typedef struct packed {
        logic  push;
        logic  load;
        logic  reduce;
        logic  emit;
        t_kind kind;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic                 winner_live;
        logic [LANE_BITS-1:0] winner_lane;
        logic                 out_free;
    } t_status;

    // a always comes from lower lanes than b, so a tie goes to a
    function automatic t_cand best(t_cand a, t_cand b);
        t_cand r;
        if (a.live && (!b.live || ($signed(a.value) <= $signed(b.value)))) begin
            r = a;
        end else begin
            r = b;
        end
        return r;
    endfunction

endpackage

### hw/rtl/kwsm_ctrl.sv
// Sequencer of the k-way merge: fill tracking, lane check and search steps.
module kwsm_ctrl (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [kwsm_pkg::LANE_BITS-1:0]     i_item_lane,
    input  logic                               i_item_end,
    input  logic                               i_cfg_we,
    input  logic [kwsm_pkg::CFG_BITS-1:0]      i_cfg_data,
    input  kwsm_pkg::t_status                  i_status,
    output kwsm_pkg::t_cmd                     o_cmd
);

    kwsm_pkg::t_state                       r_state, n_state;
    kwsm_pkg::t_kind                        r_kind, n_kind;
    logic                                   r_filling, n_filling;
    logic [kwsm_pkg::FILL_BITS-1:0]         r_fill_index, n_fill_index;
    logic [kwsm_pkg::LANE_BITS-1:0]         r_expected_lane, n_expected_lane;
    logic [kwsm_pkg::CFG_BITS-1:0]          r_active;
    logic [kwsm_pkg::LEVEL_BITS-1:0]        r_level, n_level;

    logic                                   accept;
    logic                                   lane_ok;
    logic                                   fill_last;
    logic [kwsm_pkg::LANE_BITS-1:0]         want;
    logic [kwsm_pkg::FILL_BITS-1:0]         fill_next;
    logic [kwsm_pkg::FILL_BITS-1:0]         active_count;

    // Clamp the stream count to 1..LANES
    always_comb begin
        if (r_active == '0) begin
            active_count = kwsm_pkg::FILL_BITS'(1);
        end else if (r_active > kwsm_pkg::CFG_BITS'(kwsm_pkg::LANES)) begin
            active_count = kwsm_pkg::FILL_BITS'(kwsm_pkg::LANES);
        end else begin
            active_count = kwsm_pkg::FILL_BITS'(r_active);
        end
    end

    // Lane check and fill progress
    assign accept    = (r_state == kwsm_pkg::S_IDLE) && i_in_valid;
    assign want      = r_filling ? r_fill_index[kwsm_pkg::LANE_BITS-1:0] : r_expected_lane;
    assign lane_ok   = (i_item_lane == want);
    assign fill_next = r_fill_index + kwsm_pkg::FILL_BITS'(1);
    assign fill_last = (fill_next >= active_count);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            kwsm_pkg::S_IDLE: begin
                if (accept) begin
                    if (!lane_ok) begin
                        n_state = kwsm_pkg::S_EMIT;
                    end else if (r_filling && !fill_last) begin
                        n_state = kwsm_pkg::S_IDLE;
                    end else begin
                        n_state = kwsm_pkg::S_SEARCH;
                    end
                end
            end
            kwsm_pkg::S_SEARCH: begin
                if (r_level == '0) begin
                    n_state = kwsm_pkg::S_EMIT;
                end
            end
            kwsm_pkg::S_EMIT: begin
                if (i_status.out_free) begin
                    n_state = kwsm_pkg::S_IDLE;
                end
            end
            default: n_state = kwsm_pkg::S_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_in_stall    = (r_state != kwsm_pkg::S_IDLE);
        o_cmd.push    = accept && lane_ok && !i_item_end;
        o_cmd.load    = accept;
        o_cmd.reduce  = (r_state == kwsm_pkg::S_SEARCH);
        o_cmd.emit    = (r_state == kwsm_pkg::S_EMIT) && i_status.out_free;
        o_cmd.kind    = r_kind;
    end

    // Fill, expected lane and step counter updates
    always_comb begin
        n_kind          = r_kind;
        n_filling       = r_filling;
        n_fill_index    = r_fill_index;
        n_expected_lane = r_expected_lane;
        n_level         = r_level;
        if (accept) begin
            n_kind  = lane_ok ? kwsm_pkg::K_VALUE : kwsm_pkg::K_ERROR;
            n_level = kwsm_pkg::LEVEL_BITS'(kwsm_pkg::LEVELS - 1);
            if (lane_ok && r_filling) begin
                n_fill_index = fill_next;
                if (fill_last) begin
                    n_filling = 1'b0;
                end
            end
        end
        if ((r_state == kwsm_pkg::S_SEARCH) && (r_level != '0)) begin
            n_level = r_level - kwsm_pkg::LEVEL_BITS'(1);
        end
        if (o_cmd.emit && (r_kind == kwsm_pkg::K_VALUE)) begin
            if (i_status.winner_live) begin
                n_expected_lane = i_status.winner_lane;
            end else begin
                // all streams drained: rearm for the next merge
                n_filling       = 1'b1;
                n_fill_index    = '0;
                n_expected_lane = '0;
            end
        end
    end

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= kwsm_pkg::S_IDLE;
            r_kind          <= kwsm_pkg::K_VALUE;
            r_filling       <= 1'b1;
            r_fill_index    <= '0;
            r_expected_lane <= '0;
            r_active        <= kwsm_pkg::CFG_BITS'(kwsm_pkg::LANES);
            r_level         <= '0;
        end else begin
            r_state         <= n_state;
            r_kind          <= n_kind;
            r_filling       <= n_filling;
            r_fill_index    <= n_fill_index;
            r_expected_lane <= n_expected_lane;
            r_level         <= n_level;
            if (i_cfg_we) begin
                r_active <= i_cfg_data;
            end
        end
    end

endmodule

### hw/rtl/kwsm_dp.sv
// Datapath of the k-way merge: stream heads, minimum search and result register.
module kwsm_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  kwsm_pkg::t_in_item   i_item,
    input  kwsm_pkg::t_cmd       i_cmd,
    input  logic                 i_out_stall,
    output kwsm_pkg::t_status    o_status,
    output logic                 o_out_valid,
    output kwsm_pkg::t_out_item  o_out_item
);

    logic signed [kwsm_pkg::VALUE_BITS-1:0] r_head_value [kwsm_pkg::LANES];
    logic [kwsm_pkg::LANES-1:0]             r_live;
    kwsm_pkg::t_cand                        r_cand [kwsm_pkg::SLOTS];
    kwsm_pkg::t_cand                        n_cand [kwsm_pkg::SLOTS];
    kwsm_pkg::t_out_item                    r_out, n_out;
    logic                                   r_out_valid;
    logic                                   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    assign o_status.winner_live = r_cand[0].live;
    assign o_status.winner_lane = r_cand[0].lane;
    assign o_status.out_free    = out_free;

    // Head of each stream, indexed by lane
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_head_value[i_item.item_lane] <= i_item.item_value;
        end
    end

    // Which lanes currently hold a head
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= '0;
        end else begin
            if (i_cmd.emit && (i_cmd.kind == kwsm_pkg::K_VALUE) && r_cand[0].live) begin
                r_live[r_cand[0].lane] <= 1'b0;
            end
            if (i_cmd.push) begin
                r_live[i_item.item_lane] <= 1'b1;
            end
        end
    end

    // Contenders: load with the new head bypassed, then halve once per step
    always_comb begin
        for (int k = 0; k < kwsm_pkg::SLOTS; k++) begin
            n_cand[k] = r_cand[k];
        end
        if (i_cmd.load) begin
            for (int k = 0; k < kwsm_pkg::SLOTS; k++) begin
                if (k < kwsm_pkg::LANES) begin
                    n_cand[k].lane = kwsm_pkg::LANE_BITS'(k);
                    if (i_cmd.push && (i_item.item_lane == kwsm_pkg::LANE_BITS'(k))) begin
                        n_cand[k].live  = 1'b1;
                        n_cand[k].value = i_item.item_value;
                    end else begin
                        n_cand[k].live  = r_live[k];
                        n_cand[k].value = r_head_value[k];
                    end
                end else begin
                    n_cand[k] = '0;
                end
            end
        end else if (i_cmd.reduce) begin
            for (int k = 0; k < kwsm_pkg::SLOTS / 2; k++) begin
                n_cand[k] = kwsm_pkg::best(r_cand[2*k], r_cand[2*k+1]);
            end
            for (int k = kwsm_pkg::SLOTS / 2; k < kwsm_pkg::SLOTS; k++) begin
                n_cand[k].live = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < kwsm_pkg::SLOTS; k++) begin
            r_cand[k] <= n_cand[k];
        end
    end

    // Result contents
    always_comb begin
        n_out = '0;
        if (i_cmd.kind == kwsm_pkg::K_ERROR) begin
            n_out.seq_error = 1'b1;
        end else if (r_cand[0].live) begin
            n_out.out_value = r_cand[0].value;
            n_out.out_lane  = r_cand[0].lane;
            n_out.has_value = 1'b1;
        end else begin
            n_out.merge_done = 1'b1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

### hw/rtl/k_way_sorted_merge_top.sv
// Top level of the k-way sorted merge.
//
//  channel   direction  handshake                  payload
//  in        input      i_in_valid / o_in_stall    i_in_item  (t_in_item)
//  out       output     o_out_valid / i_out_stall  o_out_item (t_out_item)
//  cfg       input      i_cfg_we                   i_cfg_data (active_lists)
//
//  A fill item that is not the last of the fill phase gives no result and no stall.
//  A lane error goes straight from idle to emit; any other item passes the search
//  state first, the pairwise minimum search over the stream heads, one tree level per cycle.
//  Input stalls from acceptance until the result is loaded into the output register;
//  the next item is taken while that result still waits for its transfer.
//  Reset is synchronous, active low; no clearing pass is needed.
module k_way_sorted_merge_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  kwsm_pkg::t_in_item               i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output kwsm_pkg::t_out_item              o_out_item,
    input  logic                             i_cfg_we,
    input  logic [kwsm_pkg::CFG_BITS-1:0]    i_cfg_data
);

    kwsm_pkg::t_cmd    cmd;
    kwsm_pkg::t_status status;

    // Sequencer
    kwsm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_item_lane (i_in_item.item_lane),
        .i_item_end  (i_in_item.lane_end),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Heads, search and result register
    kwsm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_in_item),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

### hw/rtl/kwsm_check.sv
// Port-level checker for the k-way merge, bound to the top level.
`include "k_way_sorted_merge_top_assert.svh"

module kwsm_check (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input kwsm_pkg::t_out_item  o_out_item
);

    // A result left untaken stays offered
    `KWSM_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "result dropped while stalled")

    // Each result is exactly one of value, completion or lane error
    `KWSM_ASSERT_IMP(a_one_kind, i_clk, i_rst_n, o_out_valid, $countones({o_out_item.has_value, o_out_item.merge_done, o_out_item.seq_error}) == 1, "result kind not unique")

    // Without a value the value and lane fields are zero
    `KWSM_ASSERT_IMP(a_no_value_zero, i_clk, i_rst_n, o_out_valid && !o_out_item.has_value, (o_out_item.out_value == '0) && (o_out_item.out_lane == '0), "stray value bits")

    // Reset empties the output register
    `KWSM_ASSERT_ALW(a_reset_empty, i_clk, !i_rst_n, !o_out_valid, "result present after reset")

endmodule

bind k_way_sorted_merge_top kwsm_check u_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
